### sv/mahd_pkg.sv
// shared types, code constants and lookup tables of the audio header decoder
`default_nettype none

package mahd_pkg;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;

    // reserved and special header codes
    localparam logic [1:0] VER_RESERVED   = 2'b01;
    localparam logic [1:0] LCODE_RESERVED = 2'b00;
    localparam logic [1:0] LCODE_L1       = 2'b11;
    localparam logic [1:0] LCODE_L3       = 2'b01;
    localparam logic [3:0] BR_FREE        = 4'h0;
    localparam logic [3:0] BR_BAD         = 4'hF;
    localparam logic [1:0] SR_RESERVED    = 2'b11;

    // samples per frame classes
    localparam logic [1:0] SPF_SEL_384  = 2'd0;
    localparam logic [1:0] SPF_SEL_576  = 2'd1;
    localparam logic [1:0] SPF_SEL_1152 = 2'd2;

    localparam logic [10:0] SPF_384  = 11'd384;
    localparam logic [10:0] SPF_576  = 11'd576;
    localparam logic [10:0] SPF_1152 = 11'd1152;

    // frame length scale factors
    localparam int unsigned LEN_SCALE_L1 = 12000;
    localparam int unsigned LEN_SCALE_L23 = 144000;

    // base sample rates and their reciprocals scaled by 2^32
    localparam int unsigned RECIP_SHIFT = 32;
    localparam logic [15:0] BASE_44100 = 16'd44100;
    localparam logic [15:0] BASE_48000 = 16'd48000;
    localparam logic [15:0] BASE_32000 = 16'd32000;
    localparam logic [17:0] RECIP_44100 = 18'((64'd1 << RECIP_SHIFT) / 64'd44100);
    localparam logic [17:0] RECIP_48000 = 18'((64'd1 << RECIP_SHIFT) / 64'd48000);
    localparam logic [17:0] RECIP_32000 = 18'((64'd1 << RECIP_SHIFT) / 64'd32000);

    // datapath widths of the frame length path
    localparam int unsigned NUM_W = 29;
    localparam int unsigned QEST_W = 15;

    // kbit/s by [lsf][layer code][bitrate index], layer code 3 is layer I
    localparam int unsigned KBPS_TAB [2][4][16] = '{
        '{
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
            '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}
        },
        '{
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}
        }
    };

    // decoded header fields carried down the pipeline
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  layer;
        logic        lsf;
        logic [3:0]  rate_index;
        logic [15:0] sample_rate_hz;
        logic        crc_protected;
        logic [1:0]  channel_mode;
        logic [1:0]  mode_extension;
        logic [10:0] samples_per_frame;
        logic [17:0] frame_duration_us;
        logic [18:0] bitrate_bps;
    } hdr_info_t;

    // request for the frame length path
    typedef struct packed {
        logic [8:0] kbps;
        logic [1:0] num_shift;
        logic [1:0] sr_idx;
        logic       pad;
        logic       layer_one;
    } len_req_t;

    // frame length path work in flight
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [QEST_W-1:0] q_est;
        logic [1:0]        sr_idx;
        logic              pad;
        logic              layer_one;
    } len_work_t;

    // sample rate in hertz by rate index
    function automatic logic [15:0] sample_rate_of(input logic [3:0] rate_index);
        logic [15:0] hz;
        unique case (rate_index)
            4'd0:    hz = 16'd44100;
            4'd1:    hz = 16'd48000;
            4'd2:    hz = 16'd32000;
            4'd3:    hz = 16'd22050;
            4'd4:    hz = 16'd24000;
            4'd5:    hz = 16'd16000;
            4'd6:    hz = 16'd11025;
            4'd7:    hz = 16'd12000;
            4'd8:    hz = 16'd8000;
            default: hz = 16'd0;
        endcase
        return hz;
    endfunction

    // frame duration in microseconds by rate index and frame size class
    function automatic logic [17:0] duration_of(input logic [3:0] rate_index,
                                                input logic [1:0] spf_sel);
        logic [17:0] d384;
        logic [17:0] d576;
        logic [17:0] d1152;
        logic [17:0] dur;
        unique case (rate_index)
            4'd0: begin
                d384 = 18'd8707;   d576 = 18'd13061; d1152 = 18'd26122;
            end
            4'd1: begin
                d384 = 18'd8000;   d576 = 18'd12000; d1152 = 18'd24000;
            end
            4'd2: begin
                d384 = 18'd12000;  d576 = 18'd18000; d1152 = 18'd36000;
            end
            4'd3: begin
                d384 = 18'd17414;  d576 = 18'd26122; d1152 = 18'd52244;
            end
            4'd4: begin
                d384 = 18'd16000;  d576 = 18'd24000; d1152 = 18'd48000;
            end
            4'd5: begin
                d384 = 18'd24000;  d576 = 18'd36000; d1152 = 18'd72000;
            end
            4'd6: begin
                d384 = 18'd34829;  d576 = 18'd52244; d1152 = 18'd104489;
            end
            4'd7: begin
                d384 = 18'd32000;  d576 = 18'd48000; d1152 = 18'd96000;
            end
            4'd8: begin
                d384 = 18'd48000;  d576 = 18'd72000; d1152 = 18'd144000;
            end
            default: begin
                d384 = 18'd0;      d576 = 18'd0;     d1152 = 18'd0;
            end
        endcase
        unique case (spf_sel)
            SPF_SEL_384:  dur = d384;
            SPF_SEL_576:  dur = d576;
            SPF_SEL_1152: dur = d1152;
            default:      dur = 18'd0;
        endcase
        return dur;
    endfunction

    // base sample rate by sample rate code
    function automatic logic [15:0] base_of(input logic [1:0] sr_idx);
        logic [15:0] b;
        unique case (sr_idx)
            2'd0:    b = BASE_44100;
            2'd1:    b = BASE_48000;
            2'd2:    b = BASE_32000;
            default: b = BASE_44100;
        endcase
        return b;
    endfunction

    // scaled reciprocal of the base sample rate
    function automatic logic [17:0] recip_of(input logic [1:0] sr_idx);
        logic [17:0] m;
        unique case (sr_idx)
            2'd0:    m = RECIP_44100;
            2'd1:    m = RECIP_48000;
            2'd2:    m = RECIP_32000;
            default: m = RECIP_44100;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### sv/mahd_decode.sv
// field decode, validity checks and table lookups of one header word
`default_nettype none

module mahd_decode (
    input  wire logic [31:0]         header_word,
    output mahd_pkg::hdr_info_t      info,
    output mahd_pkg::len_req_t       req
);
    import mahd_pkg::*;

    logic       sync_ok;
    logic [1:0] ver;
    logic [1:0] lcode;
    logic [3:0] br_idx;
    logic [1:0] sr_idx;
    logic       invalid;
    logic       lsf;
    logic       mpeg25;
    logic [1:0] shift;
    logic [1:0] layer;
    logic [3:0] rate_index;
    logic [1:0] spf_sel;
    logic [10:0] spf;
    logic [8:0] kbps;

    // raw header fields and checks
    assign sync_ok = &header_word[31:21];
    assign ver     = header_word[20:19];
    assign lcode   = header_word[18:17];
    assign br_idx  = header_word[15:12];
    assign sr_idx  = header_word[11:10];
    assign invalid = !sync_ok || (ver == VER_RESERVED) || (lcode == LCODE_RESERVED)
                     || (br_idx == BR_BAD) || (sr_idx == SR_RESERVED);

    // version, layer and sample rate index
    assign lsf        = header_word[20] ? !header_word[19] : 1'b1;
    assign mpeg25     = !header_word[20];
    assign shift      = {1'b0, lsf} + {1'b0, mpeg25};
    assign layer      = 2'(3'd4 - {1'b0, lcode});
    assign rate_index = {2'b00, sr_idx} + {2'b00, shift} + {1'b0, shift, 1'b0};

    // samples per frame class
    always_comb begin
        priority if (lcode == LCODE_L1) begin
            spf_sel = SPF_SEL_384;
            spf     = SPF_384;
        end else if (lcode == LCODE_L3 && lsf) begin
            spf_sel = SPF_SEL_576;
            spf     = SPF_576;
        end else begin
            spf_sel = SPF_SEL_1152;
            spf     = SPF_1152;
        end
    end

    assign kbps = 9'(KBPS_TAB[lsf][lcode][br_idx]);

    // decoded fields, cleared on a bad header
    always_comb begin
        info = '0;
        req  = '0;
        if (invalid) begin
            info.status = ST_BAD;
        end else begin
            info.status            = (br_idx == BR_FREE) ? ST_FREE : ST_OK;
            info.layer             = layer;
            info.lsf               = lsf;
            info.rate_index        = rate_index;
            info.sample_rate_hz    = sample_rate_of(rate_index);
            info.crc_protected     = !header_word[16];
            info.channel_mode      = header_word[7:6];
            info.mode_extension    = header_word[5:4];
            info.samples_per_frame = spf;
            info.frame_duration_us = duration_of(rate_index, spf_sel);
            info.bitrate_bps       = 19'({10'b0, kbps} * 19'd1000);
            req.kbps               = kbps;
            req.num_shift          = (lcode == LCODE_L3) ? {1'b0, mpeg25} : shift;
            req.sr_idx             = sr_idx;
            req.pad                = header_word[9];
            req.layer_one          = (lcode == LCODE_L1);
        end
    end

endmodule

`default_nettype wire

### sv/mpeg_audio_header_decode.sv
// top level: four stage pipeline decoding audio frame header words
//
// Usage: one 32-bit frame header word enters on the s_ channel (s_valid /
// s_ready) and exactly one decoded item leaves on the m_ channel (m_valid /
// m_ready), in order. Status reports ok, a bad header (all other fields
// zero) or free format (bit rate and frame length zero).
// An item passes the stages in order and m_valid rises once it is in the
// output register. One item is taken in every cycle until a stall at the
// output has filled all stages; the work is split over four register stages:
// decode and table lookup, frame length numerator, multiplication by the
// reciprocal of the base sample rate, and remainder correction into the output register.
// Each stage holds its own valid bit and is loaded whenever it is empty or
// its successor moves, so bubbles close up and the block keeps taking items
// while results wait in the output register. When m_ready is low the output
// register holds its item and the stages behind it fill; s_ready falls once
// all four stages hold items. Nothing is lost or repeated under stall.
// Reset (aresetn low at a clock edge) empties all stages; no other state.
`default_nettype none

module mpeg_audio_header_decode (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_header_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [1:0]       m_layer,
    output logic             m_lsf,
    output logic [3:0]       m_rate_index,
    output logic [15:0]      m_sample_rate_hz,
    output logic             m_crc_protected,
    output logic [1:0]       m_channel_mode,
    output logic [1:0]       m_mode_extension,
    output logic [10:0]      m_samples_per_frame,
    output logic [17:0]      m_frame_duration_us,
    output logic [18:0]      m_bitrate_bps,
    output logic [11:0]      m_frame_bytes
);
    import mahd_pkg::*;

    hdr_info_t dec_info;
    len_req_t  dec_req;

    // stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage payloads
    hdr_info_t info1_reg, info2_reg, info3_reg, info4_reg;
    len_req_t  req1_reg;
    len_work_t work2_reg, work2_next;
    len_work_t work3_reg, work3_next;
    logic [11:0] bytes4_reg, bytes4_next;

    // stage two, three and four arithmetic
    logic [NUM_W+17:0]   recip_prod;
    logic [15:0]         base4;
    logic [NUM_W+1:0]    base_prod;
    logic [NUM_W+1:0]    remainder;
    logic [QEST_W-1:0]   q_fixed;
    logic [QEST_W-1:0]   q_padded;
    logic [28:0]         scaled;

    mahd_decode u_decode (
        .header_word (s_header_word),
        .info        (dec_info),
        .req         (dec_req)
    );

    // handshake chain from the output back to the input
    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage two: numerator kbps times scale, shifted by the rate divisor
    always_comb begin
        scaled = 29'(req1_reg.kbps) * (req1_reg.layer_one ? 29'(LEN_SCALE_L1)
                                                          : 29'(LEN_SCALE_L23));
        work2_next           = '0;
        work2_next.num       = NUM_W'(scaled << req1_reg.num_shift);
        work2_next.sr_idx    = req1_reg.sr_idx;
        work2_next.pad       = req1_reg.pad;
        work2_next.layer_one = req1_reg.layer_one;
    end

    // stage three: quotient estimate by the scaled reciprocal
    always_comb begin
        recip_prod       = (NUM_W+18)'(work2_reg.num) * (NUM_W+18)'(recip_of(work2_reg.sr_idx));
        work3_next       = work2_reg;
        work3_next.q_est = recip_prod[RECIP_SHIFT +: QEST_W];
    end

    // stage four: remainder correction, padding and layer I slot size
    always_comb begin
        base4     = base_of(work3_reg.sr_idx);
        base_prod = (NUM_W+2)'(work3_reg.q_est) * (NUM_W+2)'(base4);
        remainder = (NUM_W+2)'(work3_reg.num) - base_prod;
        q_fixed   = work3_reg.q_est + QEST_W'(remainder >= (NUM_W+2)'(base4));
        q_padded  = q_fixed + QEST_W'(work3_reg.pad);
        if (info3_reg.status != ST_OK) begin
            bytes4_next = 12'd0;
        end else if (work3_reg.layer_one) begin
            bytes4_next = {q_padded[9:0], 2'b00};
        end else begin
            bytes4_next = q_padded[11:0];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en1) begin
            info1_reg <= dec_info;
            req1_reg  <= dec_req;
        end
        if (en2) begin
            info2_reg <= info1_reg;
            work2_reg <= work2_next;
        end
        if (en3) begin
            info3_reg <= info2_reg;
            work3_reg <= work3_next;
        end
        if (en4) begin
            info4_reg  <= info3_reg;
            bytes4_reg <= bytes4_next;
        end
    end

    // output ports
    assign m_status            = info4_reg.status;
    assign m_layer             = info4_reg.layer;
    assign m_lsf               = info4_reg.lsf;
    assign m_rate_index        = info4_reg.rate_index;
    assign m_sample_rate_hz    = info4_reg.sample_rate_hz;
    assign m_crc_protected     = info4_reg.crc_protected;
    assign m_channel_mode      = info4_reg.channel_mode;
    assign m_mode_extension    = info4_reg.mode_extension;
    assign m_samples_per_frame = info4_reg.samples_per_frame;
    assign m_frame_duration_us = info4_reg.frame_duration_us;
    assign m_bitrate_bps       = info4_reg.bitrate_bps;
    assign m_frame_bytes       = bytes4_reg;

endmodule

`default_nettype wire
